FILE: hdl/rscu_pkg.sv
// ----------------------------------------------------------------------------
// Rotor substitution cipher package
// Shared types, configuration register indexes and the rotor wiring tables.
// ----------------------------------------------------------------------------
package rscu_pkg;

  localparam int NumWirings = 9;
  localparam int Alpha      = 26;
  localparam int MaxSlots   = 4;
  localparam int CharW      = 8;

  typedef logic [4:0] letter_t;
  typedef logic [3:0] wiring_t;
  typedef logic [2:0] count_t;
  typedef logic [1:0] slot_idx_t;

  typedef enum logic [2:0] {
    CfgSlot0    = 3'd0,
    CfgSlot1    = 3'd1,
    CfgSlot2    = 3'd2,
    CfgSlot3    = 3'd3,
    CfgActive   = 3'd4,
    CfgRotation = 3'd5
  } cfg_idx_e;

  typedef enum logic {
    OpEncrypt = 1'b0,
    OpDecrypt = 1'b1
  } opcode_e;

  typedef struct packed {
    logic [CharW-1:0] in_char;
    logic             opcode;
  } in_item_t;

  typedef struct packed {
    logic [CharW-1:0] out_char;
    logic             bad_char;
  } out_item_t;

  // Configuration after range handling: legal wiring numbers, saturated
  // slot count and offset reduced modulo the alphabet.
  typedef struct packed {
    wiring_t [MaxSlots-1:0] wiring;
    count_t                 num_slots;
    letter_t                rot;
  } cfg_t;

  typedef struct packed {
    logic    enable;
    wiring_t wir_enc;
    wiring_t wir_dec;
  } stage_ctrl_t;

  typedef struct packed {
    logic [CharW-1:0] raw;
    logic             is_letter;
    logic             bad;
    logic             opcode;
    letter_t          v;
  } pipe_t;

  typedef letter_t [Alpha-1:0]      perm_t;
  typedef perm_t   [NumWirings-1:0] perm_tab_t;

  localparam logic [8*Alpha-1:0] WiringStr [NumWirings] = '{
    "ABCDEFGHIJKLMNOPQRSTUVWXYZ",
    "EKMFLGDQVZNTOWYHXUSPAIBRCJ",
    "AJDKSIRUXBLHWTMCQGZNPYFVOE",
    "BDFHJLCPRTXVZNYEIWGAKMUSQO",
    "ESOVPZJAYQUIRHXLNFTGKDCMWB",
    "VZBRGITYUPSDNHLXAWMJQOFECK",
    "JPGVOUMFYQBENHZRDKASXLICTW",
    "NZJHGRCXMYSWBOUFAIVLPEKQDT",
    "FKQHTLXOCBJSPDZRAMEWNIUYGV"
  };

  function automatic perm_tab_t build_fwd();
    perm_tab_t t;
    logic [CharW-1:0] c;
    t = '0;
    for (int w = 0; w < NumWirings; w++) begin
      for (int i = 0; i < Alpha; i++) begin
        c = WiringStr[w][CharW*(Alpha-1-i) +: CharW];
        t[w][i] = letter_t'(c - 8'd65);
      end
    end
    return t;
  endfunction

  function automatic perm_tab_t build_inv(input perm_tab_t f);
    perm_tab_t t;
    t = '0;
    for (int w = 0; w < NumWirings; w++) begin
      for (int i = 0; i < Alpha; i++) begin
        t[w][f[w][i]] = letter_t'(i);
      end
    end
    return t;
  endfunction

  localparam perm_tab_t FwdTab = build_fwd();
  localparam perm_tab_t InvTab = build_inv(FwdTab);

endpackage

FILE: hdl/rscu_cfg_regs.sv
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the slot wirings, active slot count and rotation offset, and presents
// them with out-of-range values already resolved.
// ----------------------------------------------------------------------------
module rscu_cfg_regs import rscu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_idx_i,
  input  logic [4:0] cfg_data_i,
  output cfg_t       cfg_o
);

  wiring_t [MaxSlots-1:0] wiring_q;
  count_t                 active_q;
  logic [4:0]             rot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wiring_q <= '0;
      active_q <= '0;
      rot_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgSlot0:    wiring_q[0] <= cfg_data_i[3:0];
        CfgSlot1:    wiring_q[1] <= cfg_data_i[3:0];
        CfgSlot2:    wiring_q[2] <= cfg_data_i[3:0];
        CfgSlot3:    wiring_q[3] <= cfg_data_i[3:0];
        CfgActive:   active_q    <= cfg_data_i[2:0];
        CfgRotation: rot_q       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int s = 0; s < MaxSlots; s++) begin
      cfg_o.wiring[s] = (wiring_q[s] < wiring_t'(NumWirings)) ? wiring_q[s] : '0;
    end
    cfg_o.num_slots = (active_q > count_t'(MaxSlots)) ? count_t'(MaxSlots) : active_q;
    cfg_o.rot       = (rot_q >= 5'(Alpha)) ? 5'(rot_q - 5'(Alpha)) : rot_q;
  end

endmodule

FILE: hdl/rscu_slot_stage.sv
// ----------------------------------------------------------------------------
// Rotor slot stage
// One registered pipeline stage that maps a letter through one rotated slot,
// forward for encryption or through the inverse wiring for decryption.
// ----------------------------------------------------------------------------
module rscu_slot_stage import rscu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  pipe_t       data_i,
  input  stage_ctrl_t ctrl_i,
  input  letter_t     rot_i,
  output logic        valid_o,
  output pipe_t       data_o
);

  logic    valid_q;
  pipe_t   data_q;
  pipe_t   data_d;
  letter_t idx;
  letter_t fwd_v;
  logic [5:0] inv_sum;
  letter_t inv_v;

  always_comb begin
    idx     = (data_i.v >= rot_i) ? letter_t'(data_i.v - rot_i)
                                  : letter_t'(6'(data_i.v) + 6'(Alpha) - 6'(rot_i));
    fwd_v   = FwdTab[ctrl_i.wir_enc][idx];
    inv_sum = 6'(InvTab[ctrl_i.wir_dec][data_i.v]) + 6'(rot_i);
    inv_v   = (inv_sum >= 6'(Alpha)) ? letter_t'(inv_sum - 6'(Alpha)) : letter_t'(inv_sum);
    data_d  = data_i;
    if (ctrl_i.enable && data_i.is_letter) begin
      data_d.v = (data_i.opcode == OpDecrypt) ? inv_v : fwd_v;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

FILE: hdl/rotor_substitution_cipher_unit.sv
// ----------------------------------------------------------------------------
// Rotor substitution cipher unit
// Encrypts or decrypts one ASCII character per cycle through up to four
// rotated rotor slots.
// ----------------------------------------------------------------------------
// A new character is taken in every cycle in which start is high; busy is
// always low. Each transaction yields exactly one result, shown for one cycle
// with valid_o high once the character has passed through one input register,
// one register stage per rotor slot and one output register. The receiver
// cannot stall the pipeline, so results must be taken as they come. The user
// must write configuration through the plain write port while no character is
// in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module rotor_substitution_cipher_unit import rscu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  in_item_t   in_i,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_idx_i,
  input  logic [4:0] cfg_data_i,
  output logic       valid_o,
  output out_item_t  out_o
);

  cfg_t cfg;

  rscu_cfg_regs u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  assign busy = 1'b0;

  logic  in_valid_q;
  pipe_t in_data_q;
  pipe_t in_data_d;

  always_comb begin
    in_data_d.raw       = in_i.in_char;
    in_data_d.opcode    = in_i.opcode;
    in_data_d.is_letter = (in_i.in_char >= 8'd65) && (in_i.in_char <= 8'd90);
    in_data_d.bad       = !in_data_d.is_letter && (in_i.in_char != 8'd32);
    in_data_d.v         = letter_t'(in_i.in_char - 8'd65);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    in_data_q <= in_data_d;
  end

  stage_ctrl_t [MaxSlots-1:0] ctrl;

  always_comb begin
    for (int k = 0; k < MaxSlots; k++) begin
      ctrl[k].enable  = count_t'(k) < cfg.num_slots;
      ctrl[k].wir_enc = cfg.wiring[k];
      ctrl[k].wir_dec = ctrl[k].enable
                        ? cfg.wiring[slot_idx_t'(cfg.num_slots - count_t'(k) - 3'd1)]
                        : '0;
    end
  end

  logic  [MaxSlots:0] st_valid;
  pipe_t [MaxSlots:0] st_data;

  assign st_valid[0] = in_valid_q;
  assign st_data[0]  = in_data_q;

  for (genvar k = 0; k < MaxSlots; k++) begin : g_slot
    rscu_slot_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (st_valid[k]),
      .data_i  (st_data[k]),
      .ctrl_i  (ctrl[k]),
      .rot_i   (cfg.rot),
      .valid_o (st_valid[k+1]),
      .data_o  (st_data[k+1])
    );
  end

  logic      out_valid_q;
  out_item_t out_q;
  out_item_t out_d;

  always_comb begin
    out_d.out_char = st_data[MaxSlots].is_letter
                     ? CharW'(st_data[MaxSlots].v) + 8'd65
                     : st_data[MaxSlots].raw;
    out_d.bad_char = st_data[MaxSlots].bad;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= st_valid[MaxSlots];
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign valid_o = out_valid_q;
  assign out_o   = out_q;

endmodule
